/* rtl/spe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types and constants of the shortest path eccentricity unit.
// ----------------------------------------------------------------------------
package spe_pkg;

    localparam int FIELD_W  = 11;
    localparam int WEIGHT_W = 32;
    localparam int DIST_W   = 48;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_RUN  = 1'b1;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_NO_EDGE     = 2'd1;
    localparam logic [1:0] STATUS_UNREACHABLE = 2'd2;
    localparam logic [1:0] STATUS_STORE_FULL  = 2'd3;

    typedef struct packed {
        logic                action;
        logic [FIELD_W-1:0]  node_a;
        logic [FIELD_W-1:0]  node_b;
        logic [WEIGHT_W-1:0] weight;
    } in_item_t;

    typedef struct packed {
        logic [DIST_W-1:0] max_distance;
        logic [1:0]        status;
    } out_item_t;

    // node fields are zero-based here
    typedef struct packed {
        logic                is_run;
        logic [FIELD_W-1:0]  node_a;
        logic [FIELD_W-1:0]  node_b;
        logic [WEIGHT_W-1:0] weight;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE_A,
        ST_EDGE_B,
        ST_TOUCH,
        ST_INIT,
        ST_SCAN,
        ST_HEAD,
        ST_WALK,
        ST_EDGE_RD,
        ST_NODE_RD,
        ST_DONE
    } back_state_t;

endpackage
`default_nettype wire

/* rtl/shortest_path_eccentricity_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shortest_path_eccentricity_unit
// Loads undirected weighted edges, then reports the largest shortest-path
// distance from node one, with a status.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (in_valid/in_stall/in_data) carry either one edge load or a
//   run command. Results (out_valid/out_stall/out_data) come one per run.
//   cfg_write/cfg_data set the node count; write it only while idle.
// Timing:
//   The front stage takes one request per cycle into a four-entry queue, unless
//   the queue is full. The engine stores an edge with two list-head reads on one
//   RAM port. A run does the edge check and table init, then per settled node a
//   minimum scan over the node table plus, per adjacency entry, an edge RAM read,
//   a node RAM read and an update, as the node table has a single read port.
//   After each result, and after reset, the list heads are swept clear; requests
//   queue up meanwhile.
// Stall:
//   A stalled result stays in the output register; the engine waits in its
//   done state, and the queue and front stage stall in turn once full.
// ----------------------------------------------------------------------------
module shortest_path_eccentricity_unit
    import spe_pkg::*;
#(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [FIELD_W-1:0] cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire in_item_t           in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output out_item_t               out_data
);

    logic push, q_full, pop, q_empty;
    cmd_t push_cmd, q_head;

    spe_front #(.MAX_NODES(MAX_NODES)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    spe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    spe_back #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

/* rtl/spe_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spe_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* rtl/spe_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spe_front
// Input stage: accepts requests, drops edges with bad endpoints, converts
// endpoints to zero-based node indexes and hands commands to the queue.
// ----------------------------------------------------------------------------
module spe_front
    import spe_pkg::*;
#(
    parameter int MAX_NODES = 1024
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    output logic          push,
    output cmd_t          push_cmd,
    input  wire logic     q_full
);

    logic hold_valid_reg, hold_valid_next;
    cmd_t hold_reg, hold_next;
    logic accept;
    logic edge_ok;

    assign push     = hold_valid_reg && !q_full;
    assign push_cmd = hold_reg;
    assign in_stall = hold_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;

    assign edge_ok = (in_data.node_a != '0) && (in_data.node_b != '0)
                  && (32'(in_data.node_a) <= 32'(MAX_NODES))
                  && (32'(in_data.node_b) <= 32'(MAX_NODES));

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (push)
        begin
            hold_valid_next = 1'b0;
        end
        if (accept)
        begin
            // drop an edge that names a node outside the store
            hold_valid_next  = (in_data.action == ACTION_RUN) || edge_ok;
            hold_next.is_run = (in_data.action == ACTION_RUN);
            hold_next.node_a = in_data.node_a - FIELD_W'(1);
            hold_next.node_b = in_data.node_b - FIELD_W'(1);
            hold_next.weight = in_data.weight;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule
`default_nettype wire

/* rtl/spe_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spe_queue
// Short command FIFO between the input stage and the search engine.
// ----------------------------------------------------------------------------
module spe_queue
    import spe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      head,
    output logic      empty
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = wr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_next = rd_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

/* rtl/spe_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spe_back
// Search engine: builds per-node adjacency lists, runs Dijkstra from node one
// with a minimum scan over the node table, and registers the result.
// ----------------------------------------------------------------------------
module spe_back
    import spe_pkg::*;
#(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [FIELD_W-1:0] cfg_data,
    input  wire logic               q_empty,
    input  wire cmd_t               q_head,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output out_item_t               out_data
);

    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int CNT_W       = $clog2(MAX_NODES + 1);
    localparam int ENTRY_COUNT = 2 * MAX_EDGES;
    localparam int EIDX_W      = $clog2(ENTRY_COUNT);
    localparam int PTR_W       = $clog2(ENTRY_COUNT + 1);
    localparam int EDGE_DW     = NODE_W + WEIGHT_W + PTR_W;
    localparam int NODE_DW     = 2 + DIST_W;

    back_state_t state_reg, state_next;

    logic [FIELD_W-1:0] node_count_reg;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic               bad_reg, bad_next;
    logic               found_reg, found_next;
    logic               unreach_reg, unreach_next;
    logic               overflow_reg, overflow_next;
    logic [PTR_W-1:0]   fill_reg, fill_next;
    logic               out_valid_reg, out_valid_next;

    cmd_t               cmd_reg, cmd_next;
    logic [NODE_W-1:0]  chk_reg, chk_next;
    logic [NODE_W-1:0]  pick_reg, pick_next;
    logic [DIST_W-1:0]  pick_dist_reg, pick_dist_next;
    logic [DIST_W-1:0]  maxd_reg, maxd_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [NODE_W-1:0]  dest_reg, dest_next;
    logic [DIST_W-1:0]  cand_reg, cand_next;
    logic [DIST_W-1:0]  res_dist_reg, res_dist_next;
    logic [1:0]         res_status_reg, res_status_next;
    out_item_t          out_data_reg, out_data_next;

    logic               head_we;
    logic [NODE_W-1:0]  head_waddr, head_raddr;
    logic [PTR_W-1:0]   head_wdata, head_rdata;
    logic               edge_we;
    logic [EIDX_W-1:0]  edge_waddr, edge_raddr;
    logic [EDGE_DW-1:0] edge_wdata, edge_rdata;
    logic               node_we;
    logic [NODE_W-1:0]  node_waddr, node_raddr;
    logic [NODE_DW-1:0] node_wdata, node_rdata;

    logic [31:0]        cnt_wide;
    logic [CNT_W-1:0]   n_clamped;
    logic               scan_issue, scan_done, out_free, store_full;
    logic [NODE_W-1:0]  a_idx, b_idx, head_a_idx;
    logic [PTR_W-1:0]   ptr_dec, fill_inc;
    logic [NODE_W-1:0]  e_dest;
    logic [WEIGHT_W-1:0] e_len;
    logic [PTR_W-1:0]   e_link;
    logic               n_reached, n_settled;
    logic [DIST_W-1:0]  n_dist;

    spe_ram #(.WIDTH(PTR_W), .DEPTH(MAX_NODES)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    spe_ram #(.WIDTH(EDGE_DW), .DEPTH(ENTRY_COUNT)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    spe_ram #(.WIDTH(NODE_DW), .DEPTH(MAX_NODES)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    always_comb
    begin
        cnt_wide = 32'(node_count_reg);
        if (cnt_wide == 32'd0)
        begin
            cnt_wide = 32'd1;
        end
        if (cnt_wide > 32'(MAX_NODES))
        begin
            cnt_wide = 32'(MAX_NODES);
        end
        n_clamped = CNT_W'(cnt_wide);
    end

    assign scan_issue = (idx_reg < n_reg);
    assign scan_done  = !scan_issue && !pend_reg;
    assign out_free   = !out_valid_reg || !out_stall;
    assign store_full = ({1'b0, fill_reg} + (PTR_W + 1)'(2)) > (PTR_W + 1)'(ENTRY_COUNT);
    assign a_idx      = NODE_W'(cmd_reg.node_a);
    assign b_idx      = NODE_W'(cmd_reg.node_b);
    assign head_a_idx = NODE_W'(q_head.node_a);
    assign ptr_dec    = ptr_reg - PTR_W'(1);
    assign fill_inc   = fill_reg + PTR_W'(1);
    assign {e_dest, e_len, e_link}          = edge_rdata;
    assign {n_reached, n_settled, n_dist}   = node_rdata;
    assign pop        = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (idx_reg == CNT_W'(MAX_NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_head.is_run)
                    begin
                        state_next = overflow_reg ? ST_DONE : ST_TOUCH;
                    end
                    else if (!store_full)
                    begin
                        state_next = ST_EDGE_A;
                    end
                end
            end
            ST_EDGE_A:  state_next = ST_EDGE_B;
            ST_EDGE_B:  state_next = ST_IDLE;
            ST_TOUCH:
            begin
                if (scan_done)
                begin
                    state_next = bad_reg ? ST_DONE : ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (CNT_W'(idx_reg + CNT_W'(1)) == n_reg)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = found_reg ? ST_HEAD : ST_DONE;
                end
            end
            ST_HEAD:    state_next = ST_WALK;
            ST_WALK:    state_next = (ptr_reg == '0) ? ST_SCAN : ST_EDGE_RD;
            ST_EDGE_RD: state_next = (CNT_W'(e_dest) < n_reg) ? ST_NODE_RD : ST_WALK;
            ST_NODE_RD: state_next = ST_WALK;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_CLEAR;
                end
            end
            default:    state_next = ST_CLEAR;
        endcase
    end

    // datapath and memory ports
    always_comb
    begin
        n_next          = n_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        bad_next        = bad_reg;
        found_next      = found_reg;
        unreach_next    = unreach_reg;
        overflow_next   = overflow_reg;
        fill_next       = fill_reg;
        out_valid_next  = out_valid_reg;
        cmd_next        = cmd_reg;
        chk_next        = chk_reg;
        pick_next       = pick_reg;
        pick_dist_next  = pick_dist_reg;
        maxd_next       = maxd_reg;
        ptr_next        = ptr_reg;
        dest_next       = dest_reg;
        cand_next       = cand_reg;
        res_dist_next   = res_dist_reg;
        res_status_next = res_status_reg;
        out_data_next   = out_data_reg;
        head_we    = 1'b0;
        head_waddr = idx_reg[NODE_W-1:0];
        head_wdata = '0;
        head_raddr = idx_reg[NODE_W-1:0];
        edge_we    = 1'b0;
        edge_waddr = fill_reg[EIDX_W-1:0];
        edge_wdata = '0;
        edge_raddr = ptr_dec[EIDX_W-1:0];
        node_we    = 1'b0;
        node_waddr = idx_reg[NODE_W-1:0];
        node_wdata = '0;
        node_raddr = idx_reg[NODE_W-1:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                head_we  = 1'b1;
                idx_next = idx_reg + CNT_W'(1);
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    cmd_next = q_head;
                    if (q_head.is_run)
                    begin
                        n_next    = n_clamped;
                        idx_next  = '0;
                        pend_next = 1'b0;
                        bad_next  = 1'b0;
                        res_status_next = STATUS_STORE_FULL;
                        res_dist_next   = '0;
                    end
                    else if (store_full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        head_raddr = head_a_idx;
                    end
                end
            end
            ST_EDGE_A:
            begin
                edge_we    = 1'b1;
                edge_wdata = {b_idx, cmd_reg.weight, head_rdata};
                head_we    = 1'b1;
                head_waddr = a_idx;
                head_wdata = fill_inc;
                head_raddr = b_idx;
                fill_next  = fill_inc;
            end
            ST_EDGE_B:
            begin
                edge_we = 1'b1;
                // a self loop links to the entry written in ST_EDGE_A
                if (a_idx == b_idx)
                begin
                    edge_wdata = {a_idx, cmd_reg.weight, fill_reg};
                end
                else
                begin
                    edge_wdata = {a_idx, cmd_reg.weight, head_rdata};
                end
                head_we    = 1'b1;
                head_waddr = b_idx;
                head_wdata = fill_inc;
                fill_next  = fill_inc;
            end
            ST_TOUCH:
            begin
                if (scan_issue)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                pend_next = scan_issue;
                if (pend_reg && head_rdata == '0)
                begin
                    bad_next = 1'b1;
                end
                if (scan_done)
                begin
                    idx_next        = '0;
                    res_status_next = STATUS_NO_EDGE;
                    res_dist_next   = '0;
                end
            end
            ST_INIT:
            begin
                node_we    = 1'b1;
                node_wdata = {(idx_reg == '0), 1'b0, DIST_W'(0)};
                idx_next   = idx_reg + CNT_W'(1);
                if (CNT_W'(idx_reg + CNT_W'(1)) == n_reg)
                begin
                    idx_next     = '0;
                    pend_next    = 1'b0;
                    found_next   = 1'b0;
                    unreach_next = 1'b0;
                    maxd_next    = '0;
                end
            end
            ST_SCAN:
            begin
                if (scan_issue)
                begin
                    chk_next = idx_reg[NODE_W-1:0];
                    idx_next = idx_reg + CNT_W'(1);
                end
                pend_next = scan_issue;
                if (pend_reg)
                begin
                    if (!n_reached)
                    begin
                        unreach_next = 1'b1;
                    end
                    else if (n_dist > maxd_reg)
                    begin
                        maxd_next = n_dist;
                    end
                    if (n_reached && !n_settled && (!found_reg || n_dist < pick_dist_reg))
                    begin
                        found_next     = 1'b1;
                        pick_next      = chk_reg;
                        pick_dist_next = n_dist;
                    end
                end
                if (scan_done)
                begin
                    if (found_reg)
                    begin
                        node_we    = 1'b1;
                        node_waddr = pick_reg;
                        node_wdata = {1'b1, 1'b1, pick_dist_reg};
                        head_raddr = pick_reg;
                    end
                    else
                    begin
                        res_status_next = unreach_reg ? STATUS_UNREACHABLE : STATUS_OK;
                        res_dist_next   = unreach_reg ? DIST_W'(0) : maxd_reg;
                    end
                end
            end
            ST_HEAD:
            begin
                ptr_next = head_rdata;
            end
            ST_WALK:
            begin
                if (ptr_reg == '0)
                begin
                    idx_next     = '0;
                    pend_next    = 1'b0;
                    found_next   = 1'b0;
                    unreach_next = 1'b0;
                    maxd_next    = '0;
                end
            end
            ST_EDGE_RD:
            begin
                ptr_next   = e_link;
                dest_next  = e_dest;
                cand_next  = pick_dist_reg + DIST_W'(e_len);
                node_raddr = e_dest;
            end
            ST_NODE_RD:
            begin
                if (!n_settled && (!n_reached || cand_reg < n_dist))
                begin
                    node_we    = 1'b1;
                    node_waddr = dest_reg;
                    node_wdata = {1'b1, 1'b0, cand_reg};
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_next.max_distance = res_dist_reg;
                    out_data_next.status       = res_status_reg;
                    out_valid_next = 1'b1;
                    idx_next       = '0;
                    fill_next      = '0;
                    overflow_next  = 1'b0;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            node_count_reg <= FIELD_W'(1);
            n_reg          <= CNT_W'(1);
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            bad_reg        <= 1'b0;
            found_reg      <= 1'b0;
            unreach_reg    <= 1'b0;
            overflow_reg   <= 1'b0;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_write)
            begin
                node_count_reg <= cfg_data;
            end
            n_reg          <= n_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            bad_reg        <= bad_next;
            found_reg      <= found_next;
            unreach_reg    <= unreach_next;
            overflow_reg   <= overflow_next;
            fill_reg       <= fill_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        chk_reg        <= chk_next;
        pick_reg       <= pick_next;
        pick_dist_reg  <= pick_dist_next;
        maxd_reg       <= maxd_next;
        ptr_reg        <= ptr_next;
        dest_reg       <= dest_next;
        cand_reg       <= cand_next;
        res_dist_reg   <= res_dist_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= PTR_W'(ENTRY_COUNT))
        else $error("edge store fill beyond capacity");
    a_result_then_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> state_reg == ST_CLEAR)
        else $error("result issued without clearing the store");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !pop)
        else $error("command taken while engine busy");

endmodule
`default_nettype wire
